FILE: rtl/core/ple_pkg.sv
package ple_pkg;

   localparam int DefaultCapacity = 64;
   localparam int WordWidth       = 32;
   localparam int PosWidth        = 8;
   localparam int IdxWidth        = PosWidth + 1;
   localparam int CountOutWidth   = 7;
   localparam int GroupSize       = 8;
   localparam int ReqDataWidth    = 48;
   localparam int RspDataWidth    = 48;

   typedef enum logic [3:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_INSERT_AT  = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_POP_BACK   = 4'd4,
      OP_DELETE_AT  = 4'd5,
      OP_READ_FRONT = 4'd6,
      OP_READ_BACK  = 4'd7,
      OP_READ_AT    = 4'd8,
      OP_CLEAR      = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type           kind;
      logic [IdxWidth-1:0]   at;
      logic [IdxWidth-1:0]   count;
      logic [WordWidth-1:0]  word;
      logic                  rd_en;
      logic [IdxWidth-1:0]   rd_at;
   } cell_cmd_type;

endpackage

FILE: rtl/core/ple_cell.sv
module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  ple_pkg::cell_cmd_type             cmd,
   input  logic [ple_pkg::WordWidth-1:0]     left_data,
   input  logic [ple_pkg::WordWidth-1:0]     right_data,
   output logic [ple_pkg::WordWidth-1:0]     data_out,
   output logic [ple_pkg::WordWidth-1:0]     sel_out
);
   import ple_pkg::*;

   localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(INDEX);

   logic [WordWidth-1:0] data_ff;
   logic [WordWidth-1:0] data_in;
   logic [IdxWidth-1:0]  next_idx;

   assign next_idx = MyIdx + IdxWidth'(1);

   always_comb begin
      data_in = data_ff;
      case (cmd.kind)
         CELL_INSERT: begin
            if (MyIdx == cmd.at) begin
               data_in = cmd.word;
            end else if (MyIdx > cmd.at && MyIdx <= cmd.count) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            // close the gap: entries past the deleted one move down
            if (MyIdx >= cmd.at && next_idx < cmd.count) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign sel_out  = (cmd.rd_en && MyIdx == cmd.rd_at) ? data_ff : '0;

endmodule

FILE: rtl/core/ple_chain.sv
module ple_chain #(
   parameter int CAPACITY = ple_pkg::DefaultCapacity,
   parameter int GROUPS   = (CAPACITY + ple_pkg::GroupSize - 1) / ple_pkg::GroupSize
) (
   input  logic                                        clock,
   input  ple_pkg::cell_cmd_type                       cmd,
   output logic [GROUPS-1:0][ple_pkg::WordWidth-1:0]   group_data
);
   import ple_pkg::*;

   localparam int Padded = GROUPS * GroupSize;

   logic [WordWidth-1:0] cell_data [CAPACITY];
   logic [WordWidth-1:0] cell_sel  [Padded];
   logic [GROUPS-1:0][WordWidth-1:0] group_ff;
   logic [GROUPS-1:0][WordWidth-1:0] group_in;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WordWidth-1:0] left_w;
      logic [WordWidth-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end
      ple_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i]),
         .sel_out    (cell_sel[i])
      );
   end

   for (genvar i = CAPACITY; i < Padded; i++) begin : g_pad
      assign cell_sel[i] = '0;
   end

   // first level of the read tree: OR eight cells per group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GroupSize; k++) begin
            group_in[g] = group_in[g] | cell_sel[g*GroupSize + k];
         end
      end
   end

   // hold the read word while the response waits
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         group_ff <= group_in;
      end
   end

   assign group_data = group_ff;

endmodule

FILE: rtl/core/positional_list_engine.sv
// Ordered list of up to CAPACITY 32-bit words held in a row of cells that
// shift toward their neighbors: an insert opens a gap by moving every later
// entry up one cell, a delete closes it by moving them down. Each request
// passes through capture, cell update together with the first level of the
// read OR tree (eight cells per group), then the final OR across groups into
// the response register. A new request is taken on the edge after the
// response is loaded, and the response register lets the next request in
// while a result waits on rsp_tready. Reset clears only the state, entry
// count and response valid, not the storage. Every request returns exactly
// one response; read_value is all ones unless a read succeeded.
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::DefaultCapacity
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [3:0] operation, [35:4] value, [43:36] position, [47:44] zero
   input  logic [ple_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
   output logic [ple_pkg::RspDataWidth-1:0]     rsp_tdata
);
   import ple_pkg::*;

   localparam int CntWidth = $clog2(CAPACITY + 1);
   localparam int Groups   = (CAPACITY + GroupSize - 1) / GroupSize;
   localparam logic [IdxWidth-1:0] Cap = IdxWidth'(CAPACITY);

   state_type            state_ff, state_in;
   logic [3:0]           op_ff;
   logic [WordWidth-1:0] value_ff;
   logic [PosWidth-1:0]  pos_ff;
   logic [CntWidth-1:0]  count_ff, count_in;
   status_type           status_ff, status_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   cell_cmd_type         cmd;
   logic [Groups-1:0][WordWidth-1:0] group_data;
   logic [IdxWidth-1:0]  cnt9, pos9, last9;
   logic                 full, empty;
   logic [WordWidth-1:0] rd_word;
   logic [PosWidth-1:0]  cnt_out;
   logic                 accept;

   assign cnt9  = IdxWidth'(count_ff);
   assign pos9  = {1'b0, pos_ff};
   assign last9 = cnt9 - IdxWidth'(1);
   assign full  = cnt9 >= Cap;
   assign empty = cnt9 == '0;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // decode during the execute cycle; the cells act on it at its end
   always_comb begin
      cmd       = '0;
      cmd.kind  = CELL_HOLD;
      cmd.count = cnt9;
      cmd.word  = value_ff;
      status_in = STATUS_DONE;
      count_in  = count_ff;
      rd_ok_in  = 1'b0;
      if (state_ff == ST_EXEC) begin
         case (op_ff)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else if (op_ff == OP_INSERT_AT && pos9 > cnt9) begin
                  status_in = STATUS_IGNORED;
               end else begin
                  cmd.kind = CELL_INSERT;
                  cmd.at   = (op_ff == OP_PUSH_FRONT) ? '0 :
                             (op_ff == OP_PUSH_BACK)  ? cnt9 : pos9;
                  count_in = count_ff + CntWidth'(1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
               if (empty || (op_ff == OP_DELETE_AT && pos9 >= cnt9)) begin
                  status_in = STATUS_IGNORED;
               end else begin
                  cmd.kind = CELL_DELETE;
                  cmd.at   = (op_ff == OP_POP_FRONT) ? '0 :
                             (op_ff == OP_POP_BACK)  ? last9 : pos9;
                  count_in = count_ff - CntWidth'(1);
               end
            end
            OP_READ_FRONT, OP_READ_BACK, OP_READ_AT: begin
               if (empty || (op_ff == OP_READ_AT && pos9 >= cnt9)) begin
                  status_in = STATUS_IGNORED;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_at = (op_ff == OP_READ_FRONT) ? '0 :
                              (op_ff == OP_READ_BACK)  ? last9 : pos9;
                  rd_ok_in  = 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               status_in = STATUS_IGNORED;
            end
         endcase
      end
   end

   ple_chain #(.CAPACITY(CAPACITY), .GROUPS(Groups)) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .group_data (group_data)
   );

   always_comb begin
      rd_word = '0;
      for (int g = 0; g < Groups; g++) begin
         rd_word = rd_word | group_data[g];
      end
   end

   assign cnt_out = PosWidth'(count_ff);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RspDataWidth - WordWidth - 2 - CountOutWidth)'(0),
                               cnt_out[CountOutWidth-1:0], status_ff,
                               rd_ok_ff ? rd_word : {WordWidth{1'b1}}};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tdata[3:0];
         value_ff <= req_tdata[35:4];
         pos_ff   <= req_tdata[43:36];
      end
      if (state_ff == ST_EXEC) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/ple_checker.sv
module ple_checker #(
   parameter int CAPACITY = ple_pkg::DefaultCapacity
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [ple_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ple_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import ple_pkg::*;

   localparam logic [CountOutWidth-1:0] CapOut = CountOutWidth'(CAPACITY);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("undefined status code");

   a_fail_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != STATUS_DONE |-> rsp_tdata[31:0] == '1)
      else $error("failed request returned data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && CAPACITY < 128 |-> rsp_tdata[40:34] <= CapOut)
      else $error("entry count above capacity");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
